// ----- sv/hsv_to_rgb_converter_defines.svh -----
// Assertion macros for the HSV to RGB converter RTL.
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS

// Condition implies consequence in the same cycle.
`define HSV_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsv_to_rgb_converter: same-cycle check failed");

// Condition implies consequence in the next cycle.
`define HSV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsv_to_rgb_converter: next-cycle check failed");

`else

`define HSV_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define HSV_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- sv/hsv_pkg.sv -----
// Types and constants shared by the HSV to RGB converter.
package hsv_pkg;

  // Pipeline depth
  localparam int NUM_STAGES = 7;

  // Fixed-point constants
  localparam int HUE_TURN      = 360;
  localparam int SECTOR_DEG    = 60;
  localparam int UNIT_ONE      = 256;
  localparam int SECTOR_FULL   = SECTOR_DEG * UNIT_ONE;     // 15360
  localparam int HUE_OFFSET    = HUE_TURN * 92;             // makes any 16-bit hue positive
  localparam int HUE_RECIP     = 46604;                     // ceil(2^24 / 360)
  localparam int HUE_RECIP_SH  = 24;
  localparam int DIV15_RECIP   = 4370;                      // ceil(2^16 / 15)
  localparam int DIV15_SH      = 16;

  // Sector codes
  typedef enum logic [2:0] {
    SECT_RED_YELLOW   = 3'd0,
    SECT_YELLOW_GREEN = 3'd1,
    SECT_GREEN_CYAN   = 3'd2,
    SECT_CYAN_BLUE    = 3'd3,
    SECT_BLUE_MAGENTA = 3'd4,
    SECT_MAGENTA_RED  = 3'd5
  } sector_t;

  // Per-stage load enables and valid bits
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } pipe_ctrl_t;

endpackage

// ----- sv/hsv_pipe_ctrl.sv -----
// Valid tracking and per-stage flow control for the converter pipeline.
module hsv_pipe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_valid,
  output logic               pixel_ready,
  output logic               color_valid,
  input  logic               color_ready,
  output hsv_pkg::pipe_ctrl_t ctrl
);

  logic [hsv_pkg::NUM_STAGES-1:0] valid;
  logic [hsv_pkg::NUM_STAGES-1:0] valid_next;
  logic [hsv_pkg::NUM_STAGES-1:0] load;

  // A stage loads when it is empty or its contents move on
  always_comb begin
    load[hsv_pkg::NUM_STAGES-1] = !valid[hsv_pkg::NUM_STAGES-1] || color_ready;
    for (int i = hsv_pkg::NUM_STAGES - 2; i >= 0; i--) begin
      load[i] = !valid[i] || load[i+1];
    end
  end

  // Shift valid bits along with the data, hold where stalled
  always_comb begin
    for (int i = 0; i < hsv_pkg::NUM_STAGES; i++) begin
      if (load[i]) begin
        valid_next[i] = (i == 0) ? pixel_valid : valid[(i == 0) ? 0 : i - 1];
      end else begin
        valid_next[i] = valid[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign pixel_ready = load[0];
  assign color_valid = valid[hsv_pkg::NUM_STAGES-1];
  assign ctrl.load   = load;
  assign ctrl.valid  = valid;

endmodule

// ----- sv/hsv_to_rgb_converter.sv -----
// HSV to RGB pixel converter, seven-stage pipeline.
//
// Input channel pixel_valid/pixel_ready carries one pixel: signed hue in
// degrees (wrapped modulo 360), saturation and brightness in 1/256 units
// (clamped to 0..256). Output channel color_valid/color_ready carries the
// 8-bit red, green and blue of that pixel, one transaction per pixel, in
// order.
// Register stages, in order: hue offset and reciprocal multiply, hue
// remainder, sector split, saturation products, brightness products,
// scaling by 255 with a power-of-two shift, and the divide by 15 with the
// sector permutation.
// Throughput: one pixel per clock unless color_ready is low with all
// stages full; every stage holds one transaction. When color_ready is
// low, full stages with no empty stage ahead hold their data and the
// others advance, so pixel_ready drops only once the whole pipeline is full.
// Synchronous reset clears all valid bits; the pipeline comes up empty.
`include "hsv_to_rgb_converter_defines.svh"

module hsv_to_rgb_converter (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_valid,
  output logic               pixel_ready,
  input  logic signed [15:0] hue_degrees,
  input  logic signed [10:0] saturation,
  input  logic signed [10:0] brightness,
  output logic               color_valid,
  input  logic               color_ready,
  output logic        [7:0]  red,
  output logic        [7:0]  green,
  output logic        [7:0]  blue
);

  hsv_pkg::pipe_ctrl_t ctrl;

  hsv_pipe_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .color_valid (color_valid),
    .color_ready (color_ready),
    .ctrl        (ctrl)
  );

  // Stage 1: clamp, offset hue positive, estimate hue / 360
  logic [8:0]  sat_clamp;
  logic [8:0]  val_clamp;
  logic [16:0] hue_ofs;
  logic [32:0] hue_prod;
  logic [7:0]  s1_quo;
  logic [16:0] s1_ofs;
  logic [8:0]  s1_sat;
  logic [8:0]  s1_val;

  always_comb begin
    if (saturation[10]) begin
      sat_clamp = '0;
    end else if (saturation > 11'sd256) begin
      sat_clamp = 9'(hsv_pkg::UNIT_ONE);
    end else begin
      sat_clamp = saturation[8:0];
    end
    if (brightness[10]) begin
      val_clamp = '0;
    end else if (brightness > 11'sd256) begin
      val_clamp = 9'(hsv_pkg::UNIT_ONE);
    end else begin
      val_clamp = brightness[8:0];
    end
    hue_ofs  = {hue_degrees[15], hue_degrees} + 17'(hsv_pkg::HUE_OFFSET);
    hue_prod = 33'(hue_ofs) * 33'(hsv_pkg::HUE_RECIP);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      s1_quo <= 8'(hue_prod >> hsv_pkg::HUE_RECIP_SH);
      s1_ofs <= hue_ofs;
      s1_sat <= sat_clamp;
      s1_val <= val_clamp;
    end
  end

  // Stage 2: hue remainder modulo 360
  logic [16:0] hue_rem;
  logic [8:0]  s2_hue;
  logic [8:0]  s2_sat;
  logic [8:0]  s2_val;

  assign hue_rem = s1_ofs - 17'(s1_quo) * 17'(hsv_pkg::HUE_TURN);

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      s2_hue <= hue_rem[8:0];
      s2_sat <= s1_sat;
      s2_val <= s1_val;
    end
  end

  // Stage 3: split hue into sector and offset within it
  hsv_pkg::sector_t sector_c;
  logic [8:0]       sector_base;
  logic [8:0]       sector_off;
  hsv_pkg::sector_t s3_sector;
  logic [5:0]       s3_rem;
  logic [8:0]       s3_sat;
  logic [8:0]       s3_val;

  always_comb begin
    if (s2_hue >= 9'd300) begin
      sector_c = hsv_pkg::SECT_MAGENTA_RED;
    end else if (s2_hue >= 9'd240) begin
      sector_c = hsv_pkg::SECT_BLUE_MAGENTA;
    end else if (s2_hue >= 9'd180) begin
      sector_c = hsv_pkg::SECT_CYAN_BLUE;
    end else if (s2_hue >= 9'd120) begin
      sector_c = hsv_pkg::SECT_GREEN_CYAN;
    end else if (s2_hue >= 9'd60) begin
      sector_c = hsv_pkg::SECT_YELLOW_GREEN;
    end else begin
      sector_c = hsv_pkg::SECT_RED_YELLOW;
    end
    sector_base = 9'(sector_c) * 9'(hsv_pkg::SECTOR_DEG);
    sector_off  = s2_hue - sector_base;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      s3_sector <= sector_c;
      s3_rem    <= sector_off[5:0];
      s3_sat    <= s2_sat;
      s3_val    <= s2_val;
    end
  end

  // Stage 4: saturation products for the falling and rising levels
  logic [5:0]       rem_rise;
  hsv_pkg::sector_t s4_sector;
  logic [13:0]      s4_sq;
  logic [13:0]      s4_st;
  logic [8:0]       s4_np;
  logic [8:0]       s4_val;

  assign rem_rise = 6'(hsv_pkg::SECTOR_DEG) - s3_rem;

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      s4_sector <= s3_sector;
      s4_sq     <= 14'(15'(s3_sat) * 15'(s3_rem));
      s4_st     <= 14'(15'(s3_sat) * 15'(rem_rise));
      s4_np     <= 9'(hsv_pkg::UNIT_ONE) - s3_sat;
      s4_val    <= s3_val;
    end
  end

  // Stage 5: brightness products
  logic [13:0]      nq;
  logic [13:0]      nt;
  hsv_pkg::sector_t s5_sector;
  logic [16:0]      s5_xp;
  logic [21:0]      s5_xq;
  logic [21:0]      s5_xt;
  logic [8:0]       s5_val;

  assign nq = 14'(hsv_pkg::SECTOR_FULL) - s4_sq;
  assign nt = 14'(hsv_pkg::SECTOR_FULL) - s4_st;

  always_ff @(posedge clk) begin
    if (ctrl.load[4]) begin
      s5_sector <= s4_sector;
      s5_xp     <= 17'(18'(s4_val) * 18'(s4_np));
      s5_xq     <= 22'(23'(s4_val) * 23'(nq));
      s5_xt     <= 22'(23'(s4_val) * 23'(nt));
      s5_val    <= s4_val;
    end
  end

  // Stage 6: scale by 255 and drop the power-of-two part of the divisor
  logic [29:0]      xq255;
  logic [29:0]      xt255;
  logic [24:0]      xp255;
  logic [16:0]      xv255;
  hsv_pkg::sector_t s6_sector;
  logic [11:0]      s6_yq;
  logic [11:0]      s6_yt;
  logic [7:0]       s6_lp;
  logic [7:0]       s6_lv;

  always_comb begin
    xq255 = (30'(s5_xq) << 8) - 30'(s5_xq);
    xt255 = (30'(s5_xt) << 8) - 30'(s5_xt);
    xp255 = (25'(s5_xp) << 8) - 25'(s5_xp);
    xv255 = (17'(s5_val) << 8) - 17'(s5_val);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[5]) begin
      s6_sector <= s5_sector;
      s6_yq     <= xq255[29:18];
      s6_yt     <= xt255[29:18];
      s6_lp     <= xp255[23:16];
      s6_lv     <= xv255[15:8];
    end
  end

  // Stage 7: divide by 15 and permute levels onto the channels
  logic [24:0] yq_prod;
  logic [24:0] yt_prod;
  logic [7:0]  lq;
  logic [7:0]  lt;
  logic [7:0]  red_c;
  logic [7:0]  green_c;
  logic [7:0]  blue_c;

  always_comb begin
    yq_prod = 25'(s6_yq) * 25'(hsv_pkg::DIV15_RECIP);
    yt_prod = 25'(s6_yt) * 25'(hsv_pkg::DIV15_RECIP);
    lq      = 8'(yq_prod >> hsv_pkg::DIV15_SH);
    lt      = 8'(yt_prod >> hsv_pkg::DIV15_SH);
    case (s6_sector)
      hsv_pkg::SECT_YELLOW_GREEN: begin
        red_c = lq;    green_c = s6_lv; blue_c = s6_lp;
      end
      hsv_pkg::SECT_GREEN_CYAN: begin
        red_c = s6_lp; green_c = s6_lv; blue_c = lt;
      end
      hsv_pkg::SECT_CYAN_BLUE: begin
        red_c = s6_lp; green_c = lq;    blue_c = s6_lv;
      end
      hsv_pkg::SECT_BLUE_MAGENTA: begin
        red_c = lt;    green_c = s6_lp; blue_c = s6_lv;
      end
      hsv_pkg::SECT_MAGENTA_RED: begin
        red_c = s6_lv; green_c = s6_lp; blue_c = lq;
      end
      default: begin
        red_c = s6_lv; green_c = lt;    blue_c = s6_lp;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[6]) begin
      red   <= red_c;
      green <= green_c;
      blue  <= blue_c;
    end
  end

  // Checks on internal ranges and flow control
  `HSV_ASSERT_SAME(a_hue_wrapped, clk, rst, ctrl.valid[1], s2_hue < 9'd360)
  `HSV_ASSERT_SAME(a_sector_range, clk, rst, ctrl.valid[2], s3_rem < 6'd60)
  `HSV_ASSERT_SAME(a_level_range, clk, rst, ctrl.valid[5],
                   (s6_yq < 12'd3826) && (s6_yt < 12'd3826))
  `HSV_ASSERT_SAME(a_full_stall, clk, rst, (&ctrl.valid) && !color_ready, !pixel_ready)

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the HSV to RGB pixel converter.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FULL_BYTE     = 255;
  localparam int NUM_DIRECTED  = 25;
  localparam int NUM_RANDOM    = 1300;
  localparam int PAUSE_AT      = 650;
  localparam int IDLE_LIMIT    = 1000;
  localparam int DRAIN_CYCLES  = hsv_pkg::NUM_STAGES * 4;
  localparam int RESET_CYCLES  = 9;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // One stimulus row: pixel, whether the color is typed in, and that color
  typedef struct packed {
    int hue;
    int sat;
    int bri;
    int known;
    int red;
    int green;
    int blue;
  } pixel_row_t;

  typedef enum logic [1:0] {
    RX_STREAM   = 2'd0,
    RX_RANDOM   = 2'd1,
    RX_PERIODIC = 2'd2,
    RX_LONG     = 2'd3
  } rx_mode_t;

  localparam pixel_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{0,      256,   256,   1, 255, 0,   0  },
    '{60,     256,   256,   1, 255, 255, 0  },
    '{120,    256,   256,   1, 0,   255, 0  },
    '{180,    256,   256,   1, 0,   255, 255},
    '{240,    256,   256,   1, 0,   0,   255},
    '{300,    256,   256,   1, 255, 0,   255},
    '{359,    256,   256,   0, 0,   0,   0  },
    '{360,    256,   256,   1, 255, 0,   0  },
    '{-120,   256,   256,   1, 0,   0,   255},
    '{-1,     256,   256,   0, 0,   0,   0  },
    '{-32768, 200,   180,   0, 0,   0,   0  },
    '{32767,  100,   256,   0, 0,   0,   0  },
    '{30,     0,     256,   1, 255, 255, 255},
    '{200,    -1024, 256,   1, 255, 255, 255},
    '{90,     1023,  256,   0, 0,   0,   0  },
    '{45,     128,   0,     1, 0,   0,   0  },
    '{150,    77,    -1024, 1, 0,   0,   0  },
    '{270,    256,   1023,  0, 0,   0,   0  },
    '{10,     255,   257,   0, 0,   0,   0  },
    '{215,    1,     1,     0, 0,   0,   0  },
    '{333,    -1,    128,   0, 0,   0,   0  },
    '{59,     256,   255,   0, 0,   0,   0  },
    '{61,     129,   129,   0, 0,   0,   0  },
    '{-360,   256,   256,   1, 255, 0,   0  },
    '{720,    0,     0,     1, 0,   0,   0  }
  };

  logic               clk;
  logic               rst = 1'b1;
  logic               pixel_valid = 1'b0;
  logic               pixel_ready;
  logic signed [15:0] hue_degrees = '0;
  logic signed [10:0] saturation = '0;
  logic signed [10:0] brightness = '0;
  logic               color_valid;
  logic               color_ready = 1'b0;
  logic        [7:0]  red;
  logic        [7:0]  green;
  logic        [7:0]  blue;

  rgb_t pending_colors [$];
  int   fail_count = 0;
  int   colors_checked = 0;
  int   pixels_sent = 0;
  int   idle_cycles = 0;
  int   rx_cycle = 0;

  hsv_to_rgb_converter dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .hue_degrees (hue_degrees),
    .saturation  (saturation),
    .brightness  (brightness),
    .color_valid (color_valid),
    .color_ready (color_ready),
    .red         (red),
    .green       (green),
    .blue        (blue)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Clamp a signed 1/256 quantity into 0..256
  function automatic longint clamp_unit(input int x);
    if (x < 0) return 0;
    if (x > hsv_pkg::UNIT_ONE) return hsv_pkg::UNIT_ONE;
    return x;
  endfunction

  // Scale a ratio to a byte with one final floor
  function automatic logic [7:0] to_byte(input longint num, input longint den);
    longint y;
    y = (num * FULL_BYTE) / den;
    if (y > FULL_BYTE) y = FULL_BYTE;
    return y[7:0];
  endfunction

  function automatic rgb_t hsv_to_rgb(input logic signed [15:0] hue,
                                      input logic signed [10:0] sat,
                                      input logic signed [10:0] bri);
    int         wrapped;
    int         sector;
    longint     rem;
    longint     s;
    longint     v;
    logic [7:0] lv, lp, lq, lt;
    rgb_t       c;
    wrapped = int'(hue) % hsv_pkg::HUE_TURN;
    if (wrapped < 0) wrapped += hsv_pkg::HUE_TURN;
    s = clamp_unit(int'(sat));
    v = clamp_unit(int'(bri));
    sector = wrapped / hsv_pkg::SECTOR_DEG;
    rem = wrapped % hsv_pkg::SECTOR_DEG;
    lv = to_byte(v, hsv_pkg::UNIT_ONE);
    lp = to_byte(v * (hsv_pkg::UNIT_ONE - s), hsv_pkg::UNIT_ONE * hsv_pkg::UNIT_ONE);
    lq = to_byte(v * (hsv_pkg::SECTOR_FULL - s * rem),
                 longint'(hsv_pkg::SECTOR_FULL) * hsv_pkg::UNIT_ONE);
    lt = to_byte(v * (hsv_pkg::SECTOR_FULL - s * (hsv_pkg::SECTOR_DEG - rem)),
                 longint'(hsv_pkg::SECTOR_FULL) * hsv_pkg::UNIT_ONE);
    // Assign levels to channels by sector
    case (hsv_pkg::sector_t'(sector[2:0]))
      hsv_pkg::SECT_YELLOW_GREEN: c = '{lq, lv, lp};
      hsv_pkg::SECT_GREEN_CYAN:   c = '{lp, lv, lt};
      hsv_pkg::SECT_CYAN_BLUE:    c = '{lp, lq, lv};
      hsv_pkg::SECT_BLUE_MAGENTA: c = '{lt, lp, lv};
      hsv_pkg::SECT_MAGENTA_RED:  c = '{lv, lp, lq};
      default:                    c = '{lv, lt, lp};
    endcase
    return c;
  endfunction

  function automatic int check_channel(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Offer one pixel and hold it until the transaction completes
  task automatic send_pixel(input logic signed [15:0] hue, input logic signed [10:0] sat,
                            input logic signed [10:0] bri, input logic known,
                            input rgb_t typed);
    pixel_valid <= 1'b1;
    hue_degrees <= hue;
    saturation  <= sat;
    brightness  <= bri;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    pending_colors.insert(pending_colors.size(), known ? typed : hsv_to_rgb(hue, sat, bri));
    pixels_sent++;
  endtask

  // Drop valid for a random gap when a burst runs out
  task automatic pace_burst(inout int burst_left);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        pixel_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  // Hold off the sender until every pending color has come back
  task automatic drain_pending();
    pixel_valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
  endtask

  // Stimulus: directed table, then random pixels
  initial begin
    int                 burst_left;
    int                 kind;
    logic signed [15:0] hue;
    logic signed [10:0] sat;
    logic signed [10:0] bri;
    burst_left = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      pace_burst(burst_left);
      send_pixel(16'(DIRECTED_ROWS[i].hue), 11'(DIRECTED_ROWS[i].sat),
                 11'(DIRECTED_ROWS[i].bri), DIRECTED_ROWS[i].known != 0,
                 '{8'(DIRECTED_ROWS[i].red), 8'(DIRECTED_ROWS[i].green),
                   8'(DIRECTED_ROWS[i].blue)});
    end
    drain_pending();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        hue = 16'($urandom_range(0, hsv_pkg::HUE_TURN - 1));
        sat = 11'($urandom_range(0, hsv_pkg::UNIT_ONE));
        bri = 11'($urandom_range(0, hsv_pkg::UNIT_ONE));
      end else if (kind <= 7) begin
        hue = 16'($urandom);
        sat = 11'($urandom_range(0, hsv_pkg::UNIT_ONE));
        bri = 11'($urandom_range(0, hsv_pkg::UNIT_ONE));
      end else if (kind == 8) begin
        hue = 16'($urandom);
        sat = 11'($urandom);
        bri = 11'($urandom);
      end else begin
        // Sector edges with saturation and value near the clamp limits
        hue = 16'(hsv_pkg::SECTOR_DEG * $urandom_range(0, 6) + $urandom_range(0, 2) - 1);
        sat = 11'(hsv_pkg::UNIT_ONE + $urandom_range(0, 2) - 1);
        bri = 11'($urandom_range(0, 1) ? hsv_pkg::UNIT_ONE + $urandom_range(0, 2) - 1
                                       : $urandom_range(0, 2) - 1);
      end
      if (i == PAUSE_AT) drain_pending();
      pace_burst(burst_left);
      send_pixel(hue, sat, bri, 1'b0, '0);
    end

    drain_pending();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_colors.size() != 0) begin
      $error("%0d expected colors never arrived", pending_colors.size());
      fail_count++;
    end
    $display("Sent %0d pixels (%0d directed) in random bursts, checked %0d colors",
             pixels_sent, NUM_DIRECTED, colors_checked);
    $display("under streaming, random, periodic and long output stalls.");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Receiver: stall on a pattern that rotates through four modes
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case (rx_mode_t'((rx_cycle / 256) % 4))
      RX_STREAM:   color_ready <= 1'b1;
      RX_RANDOM:   color_ready <= ($urandom_range(0, 9) < 7);
      RX_PERIODIC: color_ready <= ((rx_cycle % 13) >= 5);
      default:     color_ready <= ((rx_cycle % 128) >= 40);
    endcase
  end

  // Compare each output transaction with the oldest pending color
  always @(posedge clk) begin
    rgb_t want;
    if (!rst && color_valid && color_ready) begin
      if (pending_colors.size() == 0) begin
        $error("color %0d/%0d/%0d arrived with nothing pending", red, green, blue);
        fail_count++;
      end else begin
        want = pending_colors.pop_front();
        fail_count += check_channel("red", want.red, red);
        fail_count += check_channel("green", want.green, green);
        fail_count += check_channel("blue", want.blue, blue);
        colors_checked++;
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (pixel_valid && pixel_ready) || (color_valid && color_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $error("no transaction for %0d cycles", IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/hsv_pkg.sv
sv/hsv_pipe_ctrl.sv
sv/hsv_to_rgb_converter.sv
tb/testbench.sv
